// File: design/lsmm_pkg.sv
// Shared types and constants for the LIFO stack with running min and max.
// Holds beat structs, command codes and controller/datapath interface structs.
// No dependencies.
package lsmm_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned DEPTH_W = 11;
  localparam int unsigned CMD_W   = 2;

  // operation codes carried in the cmd field
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [WORD_W-1:0]  value;
    logic [COUNT_W-1:0]        count;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]        depth;
    logic signed [WORD_W-1:0]  top_word;
    logic signed [WORD_W-1:0]  min_word;
    logic signed [WORD_W-1:0]  max_word;
    logic                      is_empty;
    logic                      overflow;
  } out_item_t;

  // one stack entry: word plus min and max of it and everything below
  typedef struct packed {
    logic signed [WORD_W-1:0]  word;
    logic signed [WORD_W-1:0]  run_min;
    logic signed [WORD_W-1:0]  run_max;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture value and count of the accepted beat
    logic pop_set;   // commit the post-pop fill level
    logic clear;     // empty the stack
    logic push_wr;   // store one word and advance
    logic load_top;  // reload the top entry from the memory read
    logic set_ovf;   // flag a push that did not fit
    logic emit;      // load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;    // incoming count is zero
    logic full;          // stack holds STACK_DEPTH words
    logic pop_nonempty;  // a pop of the incoming count leaves words behind
    logic rem_last;      // one word left in the current push
    logic fill_last;     // one free slot left
    logic out_free;      // result register can take a new beat
  } dp_status_t;

endpackage

// File: design/lsmm_ctrl.sv
// Sequencer for the stack: accepts one beat, steps the datapath through
// the push loop or the pop reload, then hands off the result. Uses lsmm_pkg.
module lsmm_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [lsmm_pkg::CMD_W-1:0] in_cmd_i,
  output logic                     in_ready_o,
  input  lsmm_pkg::dp_status_t     status_i,
  output lsmm_pkg::ctrl_cmd_t      cmd_o
);
  import lsmm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUSH = 4'b0010,
    ST_POP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DONE;
          case (in_cmd_i)
            CMD_PUSH: begin
              if (!status_i.count_zero) begin
                if (status_i.full) begin
                  cmd_o.set_ovf = 1'b1;
                end else begin
                  state_d = ST_PUSH;
                end
              end
            end
            CMD_POP: begin
              if (!status_i.count_zero) begin
                cmd_o.pop_set = 1'b1;
                if (status_i.pop_nonempty) begin
                  state_d = ST_POP;
                end
              end
            end
            CMD_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_PUSH: begin
        cmd_o.push_wr = 1'b1;
        if (status_i.rem_last) begin
          state_d = ST_DONE;
        end else if (status_i.fill_last) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_POP: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result beat is only produced once the work for the item is over
  a_emit_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == ST_DONE)
    else $error("result loaded outside the done state");

  // the top entry reload always follows an accepted pop
  a_pop_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_top |-> $past(accept) && $past(in_cmd_i) == CMD_POP)
    else $error("top reload without a preceding pop");

  // after a beat is accepted no new beat is taken in the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second beat taken while an item is in progress");

endmodule

// File: design/lsmm_dp.sv
// Datapath for the stack: entry memory, fill level, cached top entry,
// push counters and the result register. Uses lsmm_pkg.
module lsmm_dp #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsmm_pkg::in_item_t     in_i,
  input  lsmm_pkg::ctrl_cmd_t    cmd_i,
  output lsmm_pkg::dp_status_t   status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lsmm_pkg::out_item_t    out_o
);
  import lsmm_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = (FW > COUNT_W) ? FW : COUNT_W;

  entry_t                   mem [STACK_DEPTH];
  entry_t                   rd_data_q;
  entry_t                   top_q;
  entry_t                   new_entry;
  logic [FW-1:0]            fill_q;
  logic [FW-1:0]            pop_fill;
  logic [AW-1:0]            pop_addr;
  logic [CW-1:0]            fill_ext;
  logic [CW-1:0]            cnt_ext;
  logic [COUNT_W-1:0]       rem_q;
  logic signed [WORD_W-1:0] next_word_q;
  logic                     ovf_q;
  out_item_t                out_q;
  logic                     out_valid_q;
  out_item_t                result;

  // fill level left by a pop of the incoming count
  assign fill_ext = CW'(fill_q);
  assign cnt_ext  = CW'(in_i.count);
  assign pop_fill = (cnt_ext >= fill_ext) ? '0 : FW'(fill_ext - cnt_ext);
  assign pop_addr = AW'(pop_fill - FW'(1));

  // entry for the next pushed word, folding in the running bounds below
  always_comb begin
    new_entry.word    = next_word_q;
    new_entry.run_min = next_word_q;
    new_entry.run_max = next_word_q;
    if (fill_q != '0) begin
      if (top_q.run_min < next_word_q) new_entry.run_min = top_q.run_min;
      if (top_q.run_max > next_word_q) new_entry.run_max = top_q.run_max;
    end
  end

  // entry memory: one write port for pushes, one registered read for pops
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      mem[fill_q[AW-1:0]] <= new_entry;
    end
    rd_data_q <= mem[pop_addr];
  end

  // cached top entry and push counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      top_q <= new_entry;
    end else if (cmd_i.load_top) begin
      top_q <= rd_data_q;
    end
    if (cmd_i.latch) begin
      rem_q       <= in_i.count;
      next_word_q <= in_i.value;
    end else if (cmd_i.push_wr) begin
      rem_q       <= rem_q - COUNT_W'(1);
      next_word_q <= next_word_q + 32'sd1;
    end
  end

  // fill level and overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        fill_q <= '0;
      end else if (cmd_i.pop_set) begin
        fill_q <= pop_fill;
      end else if (cmd_i.push_wr) begin
        fill_q <= fill_q + FW'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end else if (cmd_i.latch) begin
        ovf_q <= 1'b0;
      end
    end
  end

  // build the result beat from the fill level and the top entry
  always_comb begin
    result.depth    = DEPTH_W'(fill_q);
    result.is_empty = (fill_q == '0);
    result.overflow = ovf_q;
    if (fill_q == '0) begin
      result.top_word = '0;
      result.min_word = '0;
      result.max_word = '0;
    end else begin
      result.top_word = top_q.word;
      result.min_word = top_q.run_min;
      result.max_word = top_q.run_max;
    end
  end

  // result register: hold until the receiver takes the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign status_o.count_zero   = (in_i.count == '0);
  assign status_o.full         = (fill_q == FW'(STACK_DEPTH));
  assign status_o.pop_nonempty = (pop_fill != '0);
  assign status_o.rem_last     = (rem_q == COUNT_W'(1));
  assign status_o.fill_last    = (fill_q == FW'(STACK_DEPTH - 1));
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(STACK_DEPTH))
    else $error("fill level beyond capacity");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_wr |-> fill_q < FW'(STACK_DEPTH))
    else $error("push write into a full stack");

  a_reload_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_top |-> fill_q != '0)
    else $error("top reload on an empty stack");

  a_emit_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten before it was taken");

endmodule

// File: design/lifo_stack_min_max_multi.sv
// LIFO stack of signed words with per-entry running min and max.
// Top level: joins lsmm_ctrl and lsmm_dp. Uses lsmm_pkg.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per
// item: push of count words starting at value, pop of count words, or clear.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns one beat
// per item: depth, top word, min and max of stored words, empty and overflow.
// One item is in flight at a time; in_ready_o is high while the block is idle.
// From the input accept to the result: clear, no-op, zero count or push into
// a full stack go straight to the done state; a pop does so too, or first
// passes the pop state when words remain (one registered memory read reloads
// the top entry); a push writes one word per pass through the push state until
// the count or the free slots run out, since the single memory write port
// stores one word per cycle. The next beat is accepted in the cycle after the
// result is loaded.
// Reset empties the stack at once; memory contents are never cleared, since
// only entries below the fill level are ever read.
// A stalled receiver holds the result register; the finished item then waits
// and no new input beat is taken until the result can be loaded.
module lifo_stack_min_max_multi #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsmm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsmm_pkg::out_item_t out_data_o
);
  import lsmm_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  lsmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  lsmm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_data_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

// File: test/lsmm_checker.sv
`timescale 1ns / 100ps
// Checker for the LIFO stack with running min and max: watches both channels,
// predicts each result from accepted input beats and compares. Uses lsmm_pkg.
module lsmm_checker #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lsmm_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lsmm_pkg::out_item_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import lsmm_pkg::*;

  // shadow stack: word plus running min and max below it
  logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
  logic signed [WORD_W-1:0] shadow_mins  [STACK_DEPTH];
  logic signed [WORD_W-1:0] shadow_maxs  [STACK_DEPTH];
  int unsigned              shadow_fill;

  out_item_t                stack_results_due [$];
  out_item_t                due;
  int                       bad_results;

  initial begin
    shadow_fill  = 0;
    bad_results  = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  // apply one beat to the shadow stack and return the result it yields
  function automatic out_item_t apply_stack_beat(input in_item_t beat);
    out_item_t                res;
    logic signed [WORD_W-1:0] w;
    logic signed [WORD_W-1:0] lo;
    logic signed [WORD_W-1:0] hi;
    int unsigned              n;
    res = '0;
    w   = beat.value;
    case (beat.cmd)
      CMD_PUSH: begin
        for (n = 0; n < beat.count; n++) begin
          // drop the words that do not fit
          if (shadow_fill >= STACK_DEPTH) begin
            res.overflow = 1'b1;
            break;
          end
          lo = w;
          hi = w;
          if (shadow_fill > 0) begin
            if (shadow_mins[shadow_fill-1] < lo) lo = shadow_mins[shadow_fill-1];
            if (shadow_maxs[shadow_fill-1] > hi) hi = shadow_maxs[shadow_fill-1];
          end
          shadow_words[shadow_fill] = w;
          shadow_mins[shadow_fill]  = lo;
          shadow_maxs[shadow_fill]  = hi;
          shadow_fill++;
          w = w + 1;
        end
      end
      CMD_POP: begin
        shadow_fill = (beat.count >= shadow_fill) ? 0 : shadow_fill - beat.count;
      end
      CMD_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    res.depth = DEPTH_W'(shadow_fill);
    if (shadow_fill == 0) begin
      res.is_empty = 1'b1;
    end else begin
      res.top_word = shadow_words[shadow_fill-1];
      res.min_word = shadow_mins[shadow_fill-1];
      res.max_word = shadow_maxs[shadow_fill-1];
    end
    return res;
  endfunction

  // retire result beats first, then queue the prediction for a new input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (stack_results_due.size() == 0) begin
          if (bad_results < 10) begin
            $display("%0t: result beat with none due: depth %0d top %0d", $realtime,
                     out_data_i.depth, out_data_i.top_word);
          end
          bad_results++;
        end else begin
          due = stack_results_due.pop_front();
          if (out_data_i !== due) begin
            if (bad_results < 10) begin
              $display("%0t: mismatch (expected/actual): depth %0d/%0d top %0d/%0d",
                       $realtime, due.depth, out_data_i.depth,
                       due.top_word, out_data_i.top_word);
              $display("  min %0d/%0d max %0d/%0d empty %0b/%0b overflow %0b/%0b",
                       due.min_word, out_data_i.min_word,
                       due.max_word, out_data_i.max_word,
                       due.is_empty, out_data_i.is_empty,
                       due.overflow, out_data_i.overflow);
            end
            bad_results++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        stack_results_due.push_back(apply_stack_beat(in_data_i));
      end
      fail_count_o <= bad_results;
      pending_o    <= stack_results_due.size();
    end
  end

endmodule

// File: test/lifo_stack_min_max_multi_tb.sv
`timescale 1ns / 100ps
// Testbench top for lifo_stack_min_max_multi: drives directed and random
// stack beats with random gaps and stalls; lsmm_checker does the checking.
module lifo_stack_min_max_multi_tb;
  import lsmm_pkg::*;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 5000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BEATS = 840;
  localparam int unsigned MAX_COUNT = 2047;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  int          fail_count;
  int          pending;
  int unsigned cycle_count;
  bit          steady;
  bit          hold_req;

  lifo_stack_min_max_multi #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lsmm_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock and inputs known from time zero
  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // count cycles and stop a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready = steady || ($urandom_range(99) >= 15);
      end
    end
  end

  // offer one beat at the falling edge and hold it until accepted
  task automatic send_stack_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] value,
                                 input int unsigned count);
    while (!steady && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid      = 1'b1;
    in_data.cmd   = cmd;
    in_data.value = value;
    in_data.count = COUNT_W'(count);
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // pick a word, often close to the signed limits
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 32'h7FFF_FFFF - $urandom_range(15);
    if (sel == 1) return 32'h8000_0000 + $urandom_range(15);
    return $urandom;
  endfunction

  // pick a count: mostly small, sometimes medium, rarely up to the field limit
  function automatic int unsigned pick_count();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 2) return $urandom_range(MAX_COUNT, 1);
    if (sel < 10) return $urandom_range(200, 13);
    return $urandom_range(12);
  endfunction

  initial begin
    int unsigned k;
    int unsigned pick;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty-stack corners, wrap, full stack, overflow, oversized pop
    send_stack_beat(CMD_POP,    32'd0,          1);
    send_stack_beat(CMD_PUSH,   32'd0,          0);
    send_stack_beat(CMD_POP,    32'd0,          0);
    send_stack_beat(CMD_PUSH,   32'h7FFF_FFFE,  4);
    send_stack_beat(CMD_PUSH,   32'hFFFF_FFFF,  1);
    send_stack_beat(CMD_UNUSED, $urandom,       5);
    send_stack_beat(CMD_POP,    32'd0,          2);
    send_stack_beat(CMD_POP,    32'd0,          0);
    send_stack_beat(CMD_CLEAR,  32'd0,          0);
    send_stack_beat(CMD_PUSH,   32'h8000_0000,  1);
    send_stack_beat(CMD_PUSH,   32'd5,          STACK_DEPTH);
    send_stack_beat(CMD_PUSH,   32'd7,          1);
    send_stack_beat(CMD_POP,    32'd0,          1);
    send_stack_beat(CMD_PUSH,   32'd9,          1);
    send_stack_beat(CMD_POP,    32'd0,          STACK_DEPTH - 1);
    send_stack_beat(CMD_POP,    32'd0,          MAX_COUNT);
    send_stack_beat(CMD_PUSH,   32'h5555_5555,  MAX_COUNT);
    send_stack_beat(CMD_CLEAR,  32'd0,          MAX_COUNT);
    send_stack_beat(CMD_CLEAR,  32'd0,          0);
    send_stack_beat(CMD_PUSH,   32'hAAAA_AAAA,  3);
    send_stack_beat(CMD_UNUSED, 32'hFFFF_FFFF,  MAX_COUNT);
    send_stack_beat(CMD_POP,    32'hFFFF_FFFF,  MAX_COUNT);

    // random: push-heavy mix with pops, clears and unused commands
    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k == 100) hold_req = 1'b1;
      steady = (k >= 400 && k < 550);
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_stack_beat(CMD_PUSH, pick_word(), pick_count());
      end else if (pick < 80) begin
        send_stack_beat(CMD_POP, pick_word(), pick_count());
      end else if (pick < 85) begin
        send_stack_beat(CMD_CLEAR, pick_word(), pick_count());
      end else if (pick < 90) begin
        send_stack_beat(CMD_UNUSED, pick_word(), pick_count());
      end else begin
        send_stack_beat(CMD_PUSH, pick_word(), 1);
      end
    end
    steady   = 1'b0;
    in_valid = 1'b0;

    // drain outstanding results, then let the block settle
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
